// File: rtl/fmss_pkg.sv
package fmss_pkg;

  // Fixed field widths of the text, result and configuration channels.
  localparam int TEXT_W        = 8;
  localparam int PATTERN_W     = 64;
  localparam int LEN_W         = 4;
  localparam int FIRST_INDEX_W = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [PATTERN_W-1:0] PATTERN_RESET = '0;
  localparam logic [LEN_W-1:0]     LENGTH_RESET  = LEN_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1
  } cfg_reg_t;

  // Per-item control handed from the cell row to the controller.
  typedef struct packed {
    logic accept;  // an item is taken this cycle
    logic last;    // it is the final byte of the text
    logic hit;     // the window, including this byte, equals the pattern
  } step_t;

endpackage

// File: rtl/fmss_if.sv
interface fmss_text_if;
  logic                           valid;
  logic                           ready;
  logic [fmss_pkg::TEXT_W-1:0]    text_byte;
  logic                           text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface fmss_result_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [fmss_pkg::FIRST_INDEX_W-1:0]  first_index;
  logic                                index_overflow;

  modport source (output valid, output found, output first_index, output index_overflow,
                  input ready);
  modport sink   (input valid, input found, input first_index, input index_overflow,
                  output ready);
endinterface

interface fmss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fmss_pkg::CFG_INDEX_W-1:0]  index;
  logic [fmss_pkg::PATTERN_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/fmss_cell.sv
// One window position: holds a text byte, passes it on each accepted item,
// and compares the incoming byte with the pattern character that lines up here.
module fmss_cell #(
  parameter int POS = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              shift,
  input  logic [fmss_pkg::TEXT_W-1:0]       data_in,
  input  logic [fmss_pkg::PATTERN_W-1:0]    pattern_bytes,
  input  logic [fmss_pkg::LEN_W-1:0]        active_len,
  output logic [fmss_pkg::TEXT_W-1:0]       data_out,
  output logic                              eq
);

  logic [fmss_pkg::LEN_W-1:0]  sel;
  logic [fmss_pkg::TEXT_W-1:0] want;
  logic                        in_use;

  always_comb begin
    in_use = active_len > fmss_pkg::LEN_W'(POS);
    sel    = active_len - fmss_pkg::LEN_W'(1) - fmss_pkg::LEN_W'(POS);
    want   = pattern_bytes[sel[2:0]*fmss_pkg::TEXT_W +: fmss_pkg::TEXT_W];
    eq     = !in_use || (data_in == want);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_out <= '0;
    end else if (shift) begin
      data_out <= data_in;
    end
  end

endmodule

// File: rtl/fmss_ctrl.sv
// Position counter, first-match record and the result register.
module fmss_ctrl #(
  parameter int INDEX_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fmss_pkg::step_t                      step,
  input  logic [fmss_pkg::LEN_W-1:0]           active_len,
  input  logic                                 out_ready,
  output logic                                 in_ready,
  output logic                                 out_valid,
  output logic                                 found,
  output logic [fmss_pkg::FIRST_INDEX_W-1:0]   first_index,
  output logic                                 index_overflow
);

  logic [INDEX_BITS:0]   bytes_seen, bytes_seen_next, seen_plus;
  logic [INDEX_BITS:0]   len_ext, start_diff;
  logic                  match_seen, match_seen_next;
  logic [INDEX_BITS-1:0] match_start, match_start_next;
  logic                  overflow_seen, overflow_seen_next;
  logic                  load;
  logic [INDEX_BITS+fmss_pkg::FIRST_INDEX_W-1:0] start_wide;

  assign in_ready = !out_valid || out_ready;
  assign load     = step.accept && step.last;

  always_comb begin
    len_ext            = (INDEX_BITS+1)'(active_len);
    seen_plus          = bytes_seen + (INDEX_BITS+1)'(1);
    start_diff         = seen_plus - len_ext;
    bytes_seen_next    = bytes_seen;
    match_seen_next    = match_seen;
    match_start_next   = match_start;
    overflow_seen_next = overflow_seen;
    if (step.accept) begin
      if (bytes_seen[INDEX_BITS]) begin
        overflow_seen_next = 1'b1;
      end else begin
        if (!match_seen && active_len != '0 && seen_plus >= len_ext && step.hit) begin
          match_seen_next  = 1'b1;
          match_start_next = start_diff[INDEX_BITS-1:0];
        end
        bytes_seen_next = seen_plus;
      end
    end
    start_wide = {fmss_pkg::FIRST_INDEX_W'(0), match_start_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
    end else if (load) begin
      bytes_seen    <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      bytes_seen    <= bytes_seen_next;
      match_seen    <= match_seen_next;
      match_start   <= match_start_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found          <= match_seen_next;
      first_index    <= match_seen_next ? start_wide[fmss_pkg::FIRST_INDEX_W-1:0] : '0;
      index_overflow <= overflow_seen_next;
    end
  end

endmodule

// File: rtl/first_match_substring_search.sv
// First-match substring search. Text streams in on the text channel one byte
// per item, with text_end marking the final byte. A row of MAX_PATTERN cells
// holds the most recent bytes; each cell compares the byte entering it with
// the pattern character that lines up at its position, so a match that ends
// on the newest byte is seen in the same cycle the byte is accepted. The block
// takes one item every clock cycle, back to back, while its result register is not
// full and stalled. In the cycle after the final byte of a text is
// accepted, a result item appears: found, the start index of the first match
// (zero when nothing matched) and index_overflow, which is set when the text
// ran past 2^INDEX_BITS bytes. Bytes past that limit never start or end a
// match, but a match recorded before it is still reported. The result sits in
// an output register; input is held off only while that register is full and
// not being drained.
// Configuration writes (pattern_bytes at index 0, pattern_length at index 1)
// are always accepted and should be made while no text is in progress. A
// pattern_length of zero never matches and values above MAX_PATTERN are
// treated as MAX_PATTERN.
module first_match_substring_search #(
  parameter int MAX_PATTERN = 8,
  parameter int INDEX_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  fmss_cfg_if.sink      cfg,
  fmss_text_if.sink     text,
  fmss_result_if.source result
);

  logic [fmss_pkg::PATTERN_W-1:0] pattern_bytes;
  logic [fmss_pkg::LEN_W-1:0]     pattern_length;
  logic [fmss_pkg::LEN_W-1:0]     active_len;
  logic                           accept;
  fmss_pkg::step_t                step;

  // Each cell's byte feeds the next; cell 0 takes the incoming text byte.
  logic [MAX_PATTERN-1:0][fmss_pkg::TEXT_W-1:0] chain;
  logic [MAX_PATTERN-1:0][fmss_pkg::TEXT_W-1:0] cell_in;
  logic [MAX_PATTERN-1:0]                       cell_eq;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= fmss_pkg::PATTERN_RESET;
      pattern_length <= fmss_pkg::LENGTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fmss_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= cfg.data;
        fmss_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg.data[fmss_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the window size use the whole window.
  assign active_len = (pattern_length > fmss_pkg::LEN_W'(MAX_PATTERN)) ?
                      fmss_pkg::LEN_W'(MAX_PATTERN) : pattern_length;

  assign accept = text.valid && text.ready;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = text.text_byte;
    end else begin : g_link
      assign cell_in[k] = chain[k-1];
    end

    fmss_cell #(
      .POS (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .shift         (accept),
      .data_in       (cell_in[k]),
      .pattern_bytes (pattern_bytes),
      .active_len    (active_len),
      .data_out      (chain[k]),
      .eq            (cell_eq[k])
    );
  end

  // Cells beyond the pattern length report equal, so an AND over the row is
  // the full masked compare.
  assign step.accept = accept;
  assign step.last   = text.text_end;
  assign step.hit    = &cell_eq;

  fmss_ctrl #(
    .INDEX_BITS (INDEX_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .active_len     (active_len),
    .out_ready      (result.ready),
    .in_ready       (text.ready),
    .out_valid      (result.valid),
    .found          (result.found),
    .first_index    (result.first_index),
    .index_overflow (result.index_overflow)
  );

endmodule

// File: rtl/fmss_checker.sv
module fmss_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_end,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                found,
  input logic [fmss_pkg::FIRST_INDEX_W-1:0]  first_index,
  input logic                                index_overflow
);

  // A new result only follows the final byte of a text.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && !out_ready)) |->
      $past(in_valid && in_ready && in_end))
    else $error("result item without a final text byte");

  // A miss always reports index zero.
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (first_index == '0))
    else $error("first_index nonzero without a match");

  // Input is only held off by a full, stalled result register.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output is free");

  // A stalled result keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(found) && $stable(first_index) && $stable(index_overflow)))
    else $error("stalled result changed");

endmodule

bind first_match_substring_search fmss_checker u_fmss_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (text.valid),
  .in_ready       (text.ready),
  .in_end         (text.text_end),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .found          (result.found),
  .first_index    (result.first_index),
  .index_overflow (result.index_overflow)
);
